>>> sv/emi_pkg.sv
`timescale 1ns / 1ps
// Package for the eased motion interpolator: widths, codes, controller
// commands and the exp2 / sine lookup tables. No dependencies.
package emi_pkg;

  localparam int TIME_BITS  = 32;
  localparam int TABLE_BITS = 8;
  localparam int TSIZE      = (1 << TABLE_BITS) + 1;
  localparam int FRAC_SH    = 16 - TABLE_BITS;
  localparam int POS_W      = 24;
  localparam int DUR_W      = 32;
  localparam int U_W        = 16;
  localparam int CMP_W      = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = 4;
  // floor(x/3) = (x * RECIP3) >> RECIP3_SH, exact for x below 2^20
  localparam int RECIP3     = 699051;
  localparam int RECIP3_SH  = 21;
  // phase offset of minus a quarter turn, modulo one turn
  localparam int PHASE_OFS  = 49152;

  localparam longint LN2_Q30    = 64'd744261118;
  localparam longint TWO_PI_Q30 = 64'd6746518852;
  localparam longint ONE_Q30    = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X  = 3'd0,
    CFG_START_Y  = 3'd1,
    CFG_END_X    = 3'd2,
    CFG_END_Y    = 3'd3,
    CFG_DURATION = 3'd4,
    CFG_CURVE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CURVE_OUT_QUAD     = 2'd0,
    CURVE_IN_OUT_CUBIC = 2'd1,
    CURVE_OUT_ELASTIC  = 2'd2
  } curve_e;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV, ST_SQ, ST_CUBE, ST_DIV3, ST_LERPE, ST_LERPS,
    ST_SVAL, ST_ES, ST_FACTOR, ST_MULX, ST_MULY, ST_WRY, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ACCEPT, CMD_CHECK, CMD_DIV_STEP, CMD_SQ, CMD_CUBE, CMD_DIV3,
    CMD_LERPE, CMD_LERPS, CMD_SVAL, CMD_ES, CMD_FACTOR, CMD_MULX, CMD_MULY,
    CMD_WRY, CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } emi_cmd_t;

  typedef struct packed {
    logic restart;
    logic finished;
    logic cubic;
    logic elastic;
  } emi_sts_t;

  typedef logic signed [17:0] tab_entry_t;
  typedef tab_entry_t tab_t [TSIZE];

  // signed quotient truncated toward zero, shift and subtract
  function automatic longint div_trunc(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned q;
    longint unsigned r;
    bit              neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], ua[i]};
      if (r >= ub) begin
        r = r - ub;
        q[i] = 1'b1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // 2^(-num/den) in Q30 by a power series
  function automatic longint exp2neg_q30(longint num, longint den);
    longint x;
    longint term;
    longint sum;
    x = div_trunc(LN2_Q30 * num, den);
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int i = 1; i <= 14; i++) begin
      term = div_trunc(-(term * x / ONE_Q30), longint'(i));
      sum += term;
    end
    return sum;
  endfunction

  // sin over at most a quarter turn, Q16
  function automatic longint qsin_q16(longint j);
    longint a;
    longint term;
    longint sum;
    a = (TWO_PI_Q30 * j) >>> TABLE_BITS;
    term = a;
    sum = a;
    for (int i = 1; i <= 9; i++) begin
      term = term * a / ONE_Q30;
      term = term * a / ONE_Q30;
      term = div_trunc(-term, longint'(2 * i) * longint'(2 * i + 1));
      sum += term;
    end
    if (sum < 0) sum = 0;
    return (sum + 8192) >>> 14;
  endfunction

  function automatic tab_t build_exp_tab();
    tab_t t;
    longint n;
    n = longint'(1) <<< TABLE_BITS;
    for (int k = 0; k < TSIZE; k++) begin
      t[k] = tab_entry_t'((exp2neg_q30(longint'(k), n) + 8192) >>> 14);
    end
    return t;
  endfunction

  function automatic tab_t build_sin_tab();
    tab_t t;
    longint q;
    longint v;
    q = longint'(1) <<< (TABLE_BITS - 2);
    for (int k = 0; k < TSIZE; k++) begin
      if (k <= q) v = qsin_q16(k);
      else if (k <= 2 * q) v = qsin_q16(2 * q - k);
      else if (k <= 3 * q) v = -qsin_q16(k - 2 * q);
      else v = -qsin_q16(4 * q - k);
      t[k] = tab_entry_t'(v);
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_exp_tab();
  localparam tab_t SIN_TAB = build_sin_tab();

endpackage

>>> sv/emi_in_if.sv
`timescale 1ns / 1ps
// Input channel: one word is a tick with a time step or a restart.
// Standalone, no package needed.
interface emi_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] delta_time;

  modport source (output valid, kind, delta_time, input ready);
  modport sink (input valid, kind, delta_time, output ready);
endinterface

>>> sv/emi_out_if.sv
`timescale 1ns / 1ps
// Output channel: one word per input word with the held position and flags.
// Standalone, no package needed.
interface emi_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic               moving;
  logic               updated;

  modport source (output valid, pos_x, pos_y, moving, updated, input ready);
  modport sink (input valid, pos_x, pos_y, moving, updated, output ready);
endinterface

>>> sv/emi_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Standalone, no package needed.
interface emi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/emi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the eased motion interpolator: steps the datapath through
// time update, division, easing and axis update. Uses emi_pkg.
module emi_ctrl
  import emi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  emi_sts_t sts_i,
  output emi_cmd_t cmd_o
);

  state_e                 state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = CMD_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_ACCEPT;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.op = CMD_CHECK;
        cnt_d    = '0;
        if (sts_i.restart || sts_i.finished) state_d = ST_DONE;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = CMD_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == '1) state_d = sts_i.elastic ? ST_DIV3 : ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = CMD_SQ;
        state_d  = sts_i.cubic ? ST_CUBE : ST_FACTOR;
      end
      ST_CUBE: begin
        cmd_o.op = CMD_CUBE;
        state_d  = ST_FACTOR;
      end
      ST_DIV3: begin
        cmd_o.op = CMD_DIV3;
        state_d  = ST_LERPE;
      end
      ST_LERPE: begin
        cmd_o.op = CMD_LERPE;
        state_d  = ST_LERPS;
      end
      ST_LERPS: begin
        cmd_o.op = CMD_LERPS;
        state_d  = ST_SVAL;
      end
      ST_SVAL: begin
        cmd_o.op = CMD_SVAL;
        state_d  = ST_ES;
      end
      ST_ES: begin
        cmd_o.op = CMD_ES;
        state_d  = ST_FACTOR;
      end
      ST_FACTOR: begin
        cmd_o.op = CMD_FACTOR;
        state_d  = ST_MULX;
      end
      ST_MULX: begin
        cmd_o.op = CMD_MULX;
        state_d  = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.op = CMD_MULY;
        state_d  = ST_WRY;
      end
      ST_WRY: begin
        cmd_o.op = CMD_WRY;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = CMD_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/emi_dp.sv
`timescale 1ns / 1ps
// Datapath of the eased motion interpolator: config registers, elapsed time,
// restoring divider, shared multiplier, easing and axis update. Uses emi_pkg.
module emi_dp
  import emi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  emi_cmd_t                 cmd_i,
  output emi_sts_t                 sts_o,
  input  logic                     kind_i,
  input  logic [15:0]              delta_time_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  output logic                     moving_o,
  output logic                     updated_o
);

  // configuration registers
  logic signed [POS_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [DUR_W-1:0]        dur_q;
  logic [1:0]              curve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q    <= '0;
      sy_q    <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      dur_q   <= DUR_W'(1);
      curve_q <= CURVE_OUT_QUAD;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_X:  sx_q    <= cfg_data_i[POS_W-1:0];
        CFG_START_Y:  sy_q    <= cfg_data_i[POS_W-1:0];
        CFG_END_X:    ex_q    <= cfg_data_i[POS_W-1:0];
        CFG_END_Y:    ey_q    <= cfg_data_i[POS_W-1:0];
        CFG_DURATION: dur_q   <= cfg_data_i[DUR_W-1:0];
        CFG_CURVE:    curve_q <= cfg_data_i[1:0];
        default:      ;
      endcase
    end
  end

  // control state
  logic [TIME_BITS-1:0]    elapsed_q;
  logic                    running_q;
  logic                    upd_q;
  logic                    kind_q;
  logic signed [POS_W-1:0] cur_x_q, cur_y_q;

  // working registers
  logic [DUR_W:0]          rem_q;
  logic [U_W-1:0]          quo_q;
  logic [16:0]             w_q;
  logic [3:0]              n_q;
  logic [15:0]             r_q;
  logic [15:0]             ph_q;
  tab_entry_t              ae_q, as_q, e_q, s_q;
  logic signed [18:0]      f_q;
  logic signed [65:0]      prod_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic                    out_mov_q, out_upd_q;

  // elapsed time compare and saturating add
  logic [CMP_W-1:0]     el_c;
  logic [TIME_BITS:0]   el_sum;
  logic [TIME_BITS-1:0] el_sat;
  assign el_c   = CMP_W'(elapsed_q);
  assign el_sum = {1'b0, elapsed_q} + (TIME_BITS + 1)'(delta_time_i);
  assign el_sat = el_sum[TIME_BITS] ? '1 : el_sum[TIME_BITS-1:0];

  assign sts_o.restart  = (kind_q == KIND_RESTART);
  assign sts_o.finished = (el_c >= CMP_W'(dur_q));
  assign sts_o.cubic    = (curve_q == CURVE_IN_OUT_CUBIC);
  assign sts_o.elastic  = (curve_q == CURVE_OUT_ELASTIC);

  // one restoring division step
  logic [DUR_W:0] r2;
  logic           ge;
  assign r2 = {rem_q[DUR_W-1:0], 1'b0};
  assign ge = (r2 >= {1'b0, dur_q});

  // easing operands
  logic [U_W-1:0] u;
  logic [16:0]    w_c;
  logic [19:0]    x10;
  assign u   = quo_q;
  assign w_c = (sts_o.cubic && u[15]) ? (17'd65536 - 17'(u)) : 17'(u);
  assign x10 = (20'(u) << 3) + (20'(u) << 1);

  // table lookups for linear interpolation
  logic [TABLE_BITS:0]  ie, is;
  logic [FRAC_SH-1:0]   fe, fs;
  tab_entry_t           de, ds;
  assign ie = {1'b0, r_q[15:FRAC_SH]};
  assign is = {1'b0, ph_q[15:FRAC_SH]};
  assign fe = r_q[FRAC_SH-1:0];
  assign fs = ph_q[FRAC_SH-1:0];
  assign de = EXP_TAB[ie + 1'b1] - EXP_TAB[ie];
  assign ds = SIN_TAB[is + 1'b1] - SIN_TAB[is];

  // interpolated values from the product register
  tab_entry_t lerp_e, lerp_s;
  assign lerp_e = ae_q + tab_entry_t'(prod_q >>> FRAC_SH);
  assign lerp_s = as_q + tab_entry_t'(prod_q >>> FRAC_SH);

  // difference of end and start on each axis
  logic signed [POS_W:0] cx, cy;
  assign cx = (POS_W + 1)'(ex_q) - (POS_W + 1)'(sx_q);
  assign cy = (POS_W + 1)'(ey_q) - (POS_W + 1)'(sy_q);

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      CMD_SQ: begin
        mul_a = 33'(w_c);
        mul_b = 33'(w_c);
      end
      CMD_CUBE: begin
        mul_a = prod_q[32:0];
        mul_b = 33'(w_q);
      end
      CMD_DIV3: begin
        mul_a = 33'(x10);
        mul_b = 33'(RECIP3);
      end
      CMD_LERPE: begin
        mul_a = 33'(de);
        mul_b = 33'(fe);
      end
      CMD_LERPS: begin
        mul_a = 33'(ds);
        mul_b = 33'(fs);
      end
      CMD_ES: begin
        mul_a = 33'(e_q);
        mul_b = 33'(s_q);
      end
      CMD_MULX: begin
        mul_a = 33'(cx);
        mul_b = 33'(f_q);
      end
      CMD_MULY: begin
        mul_a = 33'(cy);
        mul_b = 33'(f_q);
      end
      default: ;
    endcase
  end

  // easing factor from the last product
  logic [33:0]        quad_t;
  logic [16:0]        cub_t;
  logic signed [18:0] f_c;
  assign quad_t = {1'b0, u, 17'b0} - prod_q[33:0];
  assign cub_t  = prod_q[46:30];
  always_comb begin
    if (sts_o.elastic) begin
      f_c = (u == '0) ? '0 : 19'(prod_q >>> 16) + 19'sd65536;
    end else if (sts_o.cubic) begin
      f_c = u[15] ? 19'sd65536 - 19'(cub_t) : 19'(cub_t);
    end else begin
      f_c = 19'(quad_t[33:16]);
    end
  end

  // start + round(c*f / 65536), saturated to the position range
  function automatic logic signed [POS_W-1:0] axis_pos(
    logic signed [POS_W-1:0] s,
    logic signed [65:0]      p
  );
    logic signed [44:0] rnd;
    logic signed [29:0] sum;
    rnd = p[44:0] + 45'sd32768;
    sum = 30'(s) + 30'(rnd >>> 16);
    if (sum > 30'sd8388607) return 24'sh7FFFFF;
    if (sum < -30'sd8388608) return 24'sh800000;
    return sum[POS_W-1:0];
  endfunction

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      running_q <= 1'b0;
      upd_q     <= 1'b0;
      kind_q    <= KIND_TICK;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
    end else begin
      case (cmd_i.op)
        CMD_ACCEPT: begin
          kind_q <= kind_i;
          upd_q  <= 1'b0;
          if (kind_i == KIND_RESTART) begin
            elapsed_q <= '0;
            running_q <= 1'b1;
          end else begin
            elapsed_q <= el_sat;
          end
        end
        CMD_CHECK: begin
          if (!sts_o.restart && sts_o.finished) running_q <= 1'b0;
        end
        CMD_MULY: cur_x_q <= axis_pos(sx_q, prod_q);
        CMD_WRY: begin
          cur_y_q <= axis_pos(sy_q, prod_q);
          upd_q   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_CHECK: begin
        rem_q <= {1'b0, el_c[DUR_W-1:0]};
        quo_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q <= ge ? (r2 - {1'b0, dur_q}) : r2;
        quo_q <= {quo_q[U_W-2:0], ge};
      end
      CMD_SQ: w_q <= w_c;
      CMD_DIV3: begin
        n_q <= x10[19:16];
        r_q <= x10[15:0];
      end
      CMD_LERPE: begin
        ae_q <= EXP_TAB[ie];
        ph_q <= 16'(prod_q >>> RECIP3_SH) + 16'(PHASE_OFS);
      end
      CMD_LERPS: begin
        as_q <= SIN_TAB[is];
        e_q  <= lerp_e >>> n_q;
      end
      CMD_SVAL:   s_q <= lerp_s;
      CMD_FACTOR: f_q <= f_c;
      CMD_PUBLISH: begin
        out_x_q   <= cur_x_q;
        out_y_q   <= cur_y_q;
        out_mov_q <= running_q;
        out_upd_q <= upd_q;
      end
      default: ;
    endcase
    case (cmd_i.op)
      CMD_SQ, CMD_CUBE, CMD_DIV3, CMD_LERPE, CMD_LERPS, CMD_ES, CMD_MULX,
      CMD_MULY: prod_q <= mul_a * mul_b;
      default: ;
    endcase
  end

  assign pos_x_o   = out_x_q;
  assign pos_y_o   = out_y_q;
  assign moving_o  = out_mov_q;
  assign updated_o = out_upd_q;

endmodule

>>> sv/eased_motion_interpolator_top.sv
`timescale 1ns / 1ps
// Top level of the eased motion interpolator: sequencer plus datapath.
// Uses emi_pkg, emi_in_if, emi_out_if, emi_cfg_if, emi_ctrl and emi_dp.

// Each input word gives exactly one output word. One word is processed at a
// time; the next is taken once the current one has moved to the output
// register, which may still be waiting for its sink. A restart or a tick that
// reaches the duration goes from the check step straight to the output
// register. An eased tick first runs the 16-step restoring divider that forms
// the Q0.16 progress and then the easing steps of its curve on the single
// shared 33x33 multiplier, used at most once per step. Configuration writes
// are always accepted and must be issued only while no word is in flight.
module eased_motion_interpolator_top
  import emi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  emi_in_if.sink    in_i,
  emi_out_if.source out_o,
  emi_cfg_if.sink   cfg_i
);

  emi_cmd_t cmd;
  emi_sts_t sts;

  assign cfg_i.ready = 1'b1;

  emi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  emi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (in_i.kind),
    .delta_time_i (in_i.delta_time),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .pos_x_o      (out_o.pos_x),
    .pos_y_o      (out_o.pos_y),
    .moving_o     (out_o.moving),
    .updated_o    (out_o.updated)
  );

`ifndef SYNTH
  // an accepted word always moves on to the check step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> cmd.op == CMD_CHECK)
    else $error("accepted word not checked");

  // publishing never overwrites a word still waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == CMD_PUBLISH |-> !out_o.valid || out_o.ready)
    else $error("output word overwritten");

  // a published word is presented in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == CMD_PUBLISH |=> out_o.valid)
    else $error("published word not valid");
`endif

endmodule

>>> dv/tb_eased_motion_interpolator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for eased_motion_interpolator_top: directed table plus
// random restart/tick sequences, checked word by word against an in-bench model.
// Depends on emi_pkg, emi_in_if, emi_out_if, emi_cfg_if and the block itself.
module tb_eased_motion_interpolator_top;
  import emi_pkg::*;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               moving;
    logic               updated;
  } motion_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_e;

  typedef struct {
    row_e        op;
    cfg_idx_e    idx;
    logic [31:0] val;
    logic        kind;
    logic [15:0] dt;
    bit          typed;
    motion_t     want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  emi_in_if  in_if ();
  emi_out_if out_if ();
  emi_cfg_if cfg_if ();

  eased_motion_interpolator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // model state and register copies
  longint             ex_tab[TSIZE];
  longint             sn_tab[TSIZE];
  longint unsigned    t_elapsed;
  logic signed [23:0] t_x, t_y;
  logic               t_run;
  logic signed [23:0] r_sx, r_sy, r_ex, r_ey;
  logic [31:0]        r_dur;
  logic [1:0]         r_curve;

  motion_t motion_q[$];
  row_t    rows[$];
  int      errs;
  int      n_words;
  int      n_moves;
  int      n_seen;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_left;

  // 2^(-num/den) in Q30, power series
  function automatic longint pow2_neg(longint num, longint den);
    longint x, term, sum;
    x = LN2_Q30 * num / den;
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int i = 1; i <= 14; i++) begin
      term = -(term * x / ONE_Q30) / i;
      sum += term;
    end
    return sum;
  endfunction

  // quarter-turn sine in Q16
  function automatic longint quarter_sine(longint j);
    longint a, term, sum;
    a = TWO_PI_Q30 * j / (longint'(1) <<< TABLE_BITS);
    term = a;
    sum = a;
    for (int i = 1; i <= 9; i++) begin
      term = term * a / ONE_Q30;
      term = term * a / ONE_Q30;
      term = -term / longint'((2 * i) * (2 * i + 1));
      sum += term;
    end
    if (sum < 0) sum = 0;
    return (sum + 8192) >>> 14;
  endfunction

  function automatic longint interp(bit use_sin, int unsigned ph);
    int unsigned idx, fr;
    longint a, b;
    ph = ph & 32'hFFFF;
    idx = ph >> FRAC_SH;
    fr = ph & ((1 << FRAC_SH) - 1);
    a = use_sin ? sn_tab[idx] : ex_tab[idx];
    b = use_sin ? sn_tab[idx + 1] : ex_tab[idx + 1];
    return a + (((b - a) * longint'(fr)) >>> FRAC_SH);
  endfunction

  // easing factor, Q16
  function automatic longint ease_factor(longint unsigned u);
    longint unsigned v;
    int unsigned ph, xs, n, r;
    longint e, s, su;
    su = longint'(u);
    if (r_curve == CURVE_IN_OUT_CUBIC) begin
      if (u < 32768) return longint'((4 * u * u * u) >> 32);
      v = 65536 - u;
      return 65536 - longint'((4 * v * v * v) >> 32);
    end
    if (r_curve == CURVE_OUT_ELASTIC) begin
      if (u == 0) return 0;
      ph = (int'(10 * u) / 3 + PHASE_OFS) & 32'hFFFF;
      xs = int'(10 * u);
      n = xs >> 16;
      r = xs & 32'hFFFF;
      e = interp(1'b0, r) >>> n;
      s = interp(1'b1, ph);
      return 65536 + ((e * s) >>> 16);
    end
    return (131072 * su - su * su) >>> 16;
  endfunction

  function automatic logic signed [23:0] axis_pos(logic signed [23:0] s,
                                                  logic signed [23:0] e, longint f);
    longint c, p;
    c = longint'(e) - longint'(s);
    p = longint'(s) + ((c * f + 32768) >>> 16);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[23:0];
  endfunction

  // advance the model by one word
  function automatic motion_t predict_motion(logic kind, logic [15:0] dt);
    motion_t m;
    longint unsigned u;
    longint f;
    m.updated = 1'b0;
    if (kind == KIND_RESTART) begin
      t_elapsed = 0;
      t_run = 1'b1;
    end else begin
      t_elapsed = t_elapsed + dt;
      if (t_elapsed > 64'hFFFF_FFFF) t_elapsed = 64'hFFFF_FFFF;
      if (t_elapsed >= r_dur) begin
        t_run = 1'b0;
      end else begin
        u = (t_elapsed << 16) / r_dur;
        f = ease_factor(u);
        t_x = axis_pos(r_sx, r_ex, f);
        t_y = axis_pos(r_sy, r_ey, f);
        m.updated = 1'b1;
      end
    end
    m.x = t_x;
    m.y = t_y;
    m.moving = t_run;
    return m;
  endfunction

  // one word on the input channel; valid stays high afterwards
  task automatic send_word(logic kind, logic [15:0] dt, bit typed = 0, motion_t want = '0);
    motion_t m;
    in_if.kind <= kind;
    in_if.delta_time <= dt;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    m = predict_motion(kind, dt);
    motion_q.push_back(typed ? want : m);
    n_words++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // hold the input until every expected word is back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] d);
    cfg_if.index <= idx;
    cfg_if.data <= d;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_START_X:  r_sx = d[23:0];
      CFG_START_Y:  r_sy = d[23:0];
      CFG_END_X:    r_ex = d[23:0];
      CFG_END_Y:    r_ey = d[23:0];
      CFG_DURATION: r_dur = d;
      CFG_CURVE:    r_curve = d[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic void add_cfg(cfg_idx_e idx, logic [31:0] v);
    row_t r;
    r = '{op: ROW_CFG, idx: idx, val: v, kind: 1'b0, dt: '0, typed: 0, want: '0};
    rows.push_back(r);
  endfunction

  function automatic void add_word(logic k, logic [15:0] dt, bit typed = 0,
                                   motion_t want = '0);
    row_t r;
    r = '{op: ROW_WORD, idx: CFG_START_X, val: '0, kind: k, dt: dt, typed: typed,
          want: want};
    rows.push_back(r);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h80_0000;
      1: return 32'h7F_FFFF;
      2: return 32'h0;
      default: return {8'h0, 24'($urandom())};
    endcase
  endfunction

  // random settings, then restart/tick sequences with random content
  task automatic run_phase(int items, int sp, int rp, bit pressure);
    int cnt, n;
    longint unsigned stp;
    send_idle_pct = sp;
    stall_pct = rp;
    cnt = 0;
    while (cnt < items) begin
      drain();
      cfg_write(CFG_START_X, rand_coord());
      cfg_write(CFG_START_Y, rand_coord());
      cfg_write(CFG_END_X, rand_coord());
      cfg_write(CFG_END_Y, rand_coord());
      case ($urandom_range(9))
        0: cfg_write(CFG_DURATION, $urandom_range(1, 16));
        1: cfg_write(CFG_DURATION, ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom());
        default: cfg_write(CFG_DURATION, $urandom_range(100, 400000));
      endcase
      cfg_write(CFG_CURVE, ($urandom_range(19) == 0) ? 32'd3 : $urandom_range(2));
      if (pressure) begin
        hold_left = 400;
        pressure = 0;
      end
      n = $urandom_range(3, 14);
      stp = r_dur / n * 2;
      if (stp > 65535) stp = 65535;
      send_word(KIND_RESTART, 16'($urandom()));
      cnt++;
      sender_gap();
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(19))
          0, 1: send_word(KIND_TICK, 16'($urandom()));
          2:    send_word(1'($urandom()), 16'($urandom()));
          default: send_word(KIND_TICK, 16'($urandom_range(0, int'(stp))));
        endcase
        cnt++;
        sender_gap();
      end
    end
  endtask

  // result side: check each accepted word, then pick next ready
  always @(posedge clk_i) begin
    motion_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_seen++;
      if (motion_q.size() == 0) begin
        $error("unexpected output word: x=%0d y=%0d", out_if.pos_x, out_if.pos_y);
        errs++;
      end else begin
        w = motion_q.pop_front();
        if (w.updated) n_moves++;
        if (out_if.pos_x !== w.x) begin
          $error("pos_x expected %0d got %0d", w.x, out_if.pos_x);
          errs++;
        end
        if (out_if.pos_y !== w.y) begin
          $error("pos_y expected %0d got %0d", w.y, out_if.pos_y);
          errs++;
        end
        if (out_if.moving !== w.moving) begin
          $error("moving expected %0b got %0b", w.moving, out_if.moving);
          errs++;
        end
        if (out_if.updated !== w.updated) begin
          $error("updated expected %0b got %0b", w.updated, out_if.updated);
          errs++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    longint nq;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_TICK;
    in_if.delta_time = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_START_X;
    cfg_if.data = '0;
    errs = 0;
    n_words = 0;
    n_moves = 0;
    n_seen = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;

    // lookup tables, same construction as the block's
    nq = (longint'(1) <<< TABLE_BITS) / 4;
    for (int k = 0; k < TSIZE; k++) begin
      ex_tab[k] = (pow2_neg(k, nq * 4) + 8192) >>> 14;
      if (k <= nq) sn_tab[k] = quarter_sine(k);
      else if (k <= 2 * nq) sn_tab[k] = quarter_sine(2 * nq - k);
      else if (k <= 3 * nq) sn_tab[k] = -quarter_sine(k - 2 * nq);
      else sn_tab[k] = -quarter_sine(4 * nq - k);
    end
    t_elapsed = 0;
    t_x = '0;
    t_y = '0;
    t_run = 1'b0;
    r_sx = '0;
    r_sy = '0;
    r_ex = '0;
    r_ey = '0;
    r_dur = 32'd1;
    r_curve = CURVE_OUT_QUAD;

    // directed table: reset defaults, extremes, every curve, odd settings
    add_word(KIND_TICK, 16'd0, 1, '{x: 0, y: 0, moving: 0, updated: 1});
    add_word(KIND_TICK, 16'd1, 1, '{x: 0, y: 0, moving: 0, updated: 0});
    add_word(KIND_RESTART, 16'hFFFF, 1, '{x: 0, y: 0, moving: 1, updated: 0});
    add_word(KIND_TICK, 16'hFFFF, 1, '{x: 0, y: 0, moving: 0, updated: 0});
    add_cfg(CFG_START_X, 32'h80_0000);
    add_cfg(CFG_START_Y, 32'h7F_FFFF);
    add_cfg(CFG_END_X, 32'h7F_FFFF);
    add_cfg(CFG_END_Y, 32'h80_0000);
    add_cfg(CFG_DURATION, 32'd100000);
    add_word(KIND_RESTART, 16'd0);
    add_word(KIND_TICK, 16'd0, 1, '{x: -24'sd8388608, y: 24'sd8388607, moving: 1, updated: 1});
    add_word(KIND_TICK, 16'hFFFF);
    add_word(KIND_TICK, 16'hFFFF);
    add_cfg(CFG_CURVE, CURVE_IN_OUT_CUBIC);
    add_word(KIND_RESTART, 16'd0);
    add_word(KIND_TICK, 16'd30000);
    add_word(KIND_TICK, 16'd30000);
    add_word(KIND_TICK, 16'd30000);
    add_cfg(CFG_CURVE, CURVE_OUT_ELASTIC);
    add_word(KIND_RESTART, 16'd0);
    add_word(KIND_TICK, 16'd1);
    add_word(KIND_TICK, 16'd20000);
    add_word(KIND_TICK, 16'd40000);
    add_word(KIND_TICK, 16'd39000);
    add_cfg(CFG_CURVE, 32'd3);
    add_word(KIND_RESTART, 16'd0);
    add_word(KIND_TICK, 16'd50000);
    add_cfg(CFG_DURATION, 32'd0);
    add_word(KIND_RESTART, 16'd0);
    add_word(KIND_TICK, 16'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < rows.size(); i++) begin
      if (rows[i].op == ROW_CFG) begin
        if (i == 0 || rows[i - 1].op != ROW_CFG) drain();
        cfg_write(rows[i].idx, rows[i].val);
      end else begin
        send_word(rows[i].kind, rows[i].dt, rows[i].typed, rows[i].want);
      end
    end

    // random part over the idling mixes; the first one also backs up the output
    run_phase(300, 0, 0, 1);
    run_phase(310, 74, 0, 0);
    run_phase(310, 0, 74, 0);
    run_phase(310, 12, 12, 0);

    // full-range duration with the elastic curve
    drain();
    send_idle_pct = 0;
    stall_pct = 0;
    cfg_write(CFG_DURATION, 32'hFFFF_FFFF);
    cfg_write(CFG_CURVE, CURVE_OUT_ELASTIC);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_RESTART, 16'd0);
    for (int i = 0; i < 8; i++) send_word(KIND_TICK, 16'($urandom()));
    drain();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d input words and %0d output words, %0d with a new position,",
             n_words, n_seen, n_moves);
    $display("over all curves, extreme settings, position clamping and four idling mixes.");
    if (errs == 0 && motion_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
